// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers for the k-mer match counter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on a given clock and active-low reset
`define ASSERT_AT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// assert a property on clk and arst_n
`define ASSERT_CLK(lbl, prop, msg) \
	`ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

// File: rtl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, constants and hash helpers of the k-mer match counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmc_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int QUEUE_DEPTH    = 2;
	localparam int KMER_W         = 64;
	localparam int COUNT_W        = 32;
	localparam int UNIQUE_W       = 11;
	localparam int KLEN_W         = 6;
	localparam int RIDX_W         = 10;
	localparam logic [KLEN_W-1:0] K_RESET = 6'd31;

	localparam logic [63:0] BASE_CONST [4] = '{
		64'hba64e57c490e2ef4, 64'h4938a808abe1edcf,
		64'h715849e4da68576a, 64'h02db58f212586265
	};

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_STREAM = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ADDED   = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              lookup;
		logic [KMER_W-1:0] key;
	} job_t;

	typedef struct packed {
		status_t             status;
		logic                window_full;
		logic                matched;
		logic                entry_valid;
		logic [KMER_W-1:0]   entry_kmer;
		logic [COUNT_W-1:0]  entry_count;
		logic [UNIQUE_W-1:0] unique_total;
	} result_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
		return (x << r) | (x >> (7'd64 - {1'b0, r}));
	endfunction

	function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] k);
		if (k == 6'd0)
			return 6'd1;
		else if (k > 6'd32)
			return 6'd32;
		return k;
	endfunction

	function automatic logic [63:0] kmer_mask(input logic [KLEN_W-1:0] k);
		if (k >= 6'd32)
			return '1;
		return (64'd1 << {k, 1'b0}) - 64'd1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/kmc_fifo.sv
// ----------------------------------------------------------------------------
// kmc_fifo
// Small synchronous queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = store_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			store_q[wptr_q] <= din;
	end

endmodule

`default_nettype wire

// File: rtl/kmc_front.sv
// ----------------------------------------------------------------------------
// kmc_front
// Accepts commands, hands jobs to the probe engine, keeps the stream window
// and rolling hash, hashes reference k-mers four bases a cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmc_front import kmc_pkg::*; #(
	parameter int IDX_W = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          cmd,
	input  wire logic                seq_start,
	input  wire logic [1:0]          nucleotide,
	input  wire logic [KMER_W-1:0]   kmer_in,
	input  wire logic [RIDX_W-1:0]   read_index,
	input  wire logic                cfg_we,
	input  wire logic [KLEN_W-1:0]   cfg_data,
	input  wire logic                clearing,
	output logic                     jq_push,
	output logic [$bits(job_t)+IDX_W-1:0] jq_data,
	input  wire logic                jq_full
);
	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_HASH = 2'b10
	} fstate_t;

	fstate_t           state_q;
	logic [KLEN_W-1:0] k_q, fill_q, pos_q;
	logic [63:0]       window_q, hash_q, hkmer_q, hacc_q, key_q;

	logic [KLEN_W-1:0] keff, km1, f0, f1;
	logic [63:0]       w0, h0, w1, h1, hstep, nuc64;
	logic              accept, lookup, hlast;
	logic [IDX_W+RIDX_W-1:0] ridx_ext;
	job_t              job;
	logic [IDX_W-1:0]  jidx;

	assign keff     = eff_k(k_q);
	assign km1      = keff - 6'd1;
	assign full     = (state_q != F_IDLE) || jq_full || clearing;
	assign accept   = push && !full;
	assign nuc64    = {62'd0, nucleotide};
	assign ridx_ext = {{IDX_W{1'b0}}, read_index};

	always_comb begin
		w0 = seq_start ? '0 : window_q;
		h0 = seq_start ? '0 : hash_q;
		f0 = seq_start ? '0 : fill_q;
		if (f0 < keff) begin
			w1 = w0 | (nuc64 << {f0, 1'b0});
			h1 = rotl64(h0, 6'd2) ^ BASE_CONST[nucleotide];
			f1 = f0 + 6'd1;
		end else begin
			w1 = (w0 >> 2) | (nuc64 << {km1[4:0], 1'b0});
			h1 = rotl64(h0 ^ rotl64(BASE_CONST[w0[1:0]], {km1[4:0], 1'b0}), 6'd2)
				^ BASE_CONST[nucleotide];
			f1 = f0;
		end
		lookup = (f1 >= keff);
	end

	always_comb begin
		hstep = hacc_q;
		for (int j = 0; j < 4; j++) begin
			if ((7'(pos_q) + 7'(j)) < 7'(keff))
				hstep = rotl64(hstep, 6'd2) ^ BASE_CONST[hkmer_q[2*j +: 2]];
		end
		hlast = (7'(pos_q) + 7'd4) >= 7'(keff);
	end

	always_comb begin
		jq_push    = 1'b0;
		job.cmd    = cmd_t'(cmd);
		job.lookup = 1'b0;
		job.key    = '0;
		jidx       = '0;
		unique case (state_q)
			F_IDLE: begin
				if (accept && cmd_t'(cmd) != CMD_INSERT) begin
					jq_push = 1'b1;
					if (cmd_t'(cmd) == CMD_STREAM) begin
						job.lookup = lookup;
						job.key    = w1;
						jidx       = h1[IDX_W-1:0];
					end else begin
						jidx = ridx_ext[IDX_W-1:0];
					end
				end
			end
			F_HASH: begin
				job.cmd    = CMD_INSERT;
				job.key    = key_q;
				jidx       = hstep[IDX_W-1:0];
				jq_push    = hlast && !jq_full;
			end
			default: ;
		endcase
	end

	assign jq_data = {job, jidx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			k_q      <= K_RESET;
			window_q <= '0;
			hash_q   <= '0;
			fill_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && cmd_t'(cmd) == CMD_INSERT)
						state_q <= F_HASH;
					if (accept && cmd_t'(cmd) == CMD_STREAM) begin
						window_q <= w1;
						hash_q   <= h1;
						fill_q   <= f1;
					end
				end
				F_HASH: begin
					if (hlast && !jq_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
			if (cfg_we) begin
				k_q      <= cfg_data;
				window_q <= '0;
				hash_q   <= '0;
				fill_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			key_q   <= kmer_in & kmer_mask(keff);
			hkmer_q <= kmer_in & kmer_mask(keff);
			hacc_q  <= '0;
			pos_q   <= '0;
		end else if (!jq_full) begin
			hkmer_q <= hkmer_q >> 8;
			hacc_q  <= hstep;
			pos_q   <= pos_q + 6'd4;
		end
	end

endmodule

`default_nettype wire

// File: rtl/kmc_back.sv
// ----------------------------------------------------------------------------
// kmc_back
// Probe engine: owns the slot table, clears it after reset, probes linearly
// one slot a cycle and builds one result per job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmc_back import kmc_pkg::*; #(
	parameter int TABLE_SIZE = 1024,
	parameter int IDX_W      = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         jq_empty,
	input  wire logic [$bits(job_t)+IDX_W-1:0] jq_data,
	output logic                              jq_pop,
	input  wire logic                         rq_full,
	output logic                              rq_push,
	output result_t                           res,
	output logic                              clearing
);
	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_PROBE = 3'b100
	} bstate_t;

	localparam logic [UNIQUE_W-1:0] UNIQUE_MAX = '1;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
	localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(TABLE_SIZE - 1);

	logic              vmem [TABLE_SIZE];
	logic [KMER_W-1:0] kmem [TABLE_SIZE];
	logic [COUNT_W-1:0] cmem [TABLE_SIZE];

	bstate_t             state_q, state_d;
	logic [IDX_W-1:0]    clr_q, idx_q, idx_d, n_q, n_d, rd_addr;
	logic [UNIQUE_W-1:0] unique_q, unique_d;
	job_t                job_q, jq_job;
	logic [IDX_W-1:0]    jq_idx;
	logic                rd_en, v_we, v_wd, k_we, c_we;
	logic [IDX_W-1:0]    v_wa;
	logic [COUNT_W-1:0]  c_wd;
	logic                v_rd;
	logic [KMER_W-1:0]   k_rd;
	logic [COUNT_W-1:0]  c_rd;
	logic                hit, last, needs;

	assign jq_job   = job_t'(jq_data[$bits(job_t)+IDX_W-1:IDX_W]);
	assign jq_idx   = jq_data[IDX_W-1:0];
	assign clearing = (state_q == B_CLEAR);
	assign hit      = v_rd && (k_rd == job_q.key);
	assign last     = (n_q == IDX_LAST);
	assign needs    = (jq_job.cmd == CMD_INSERT) || (jq_job.cmd == CMD_READ)
		|| (jq_job.cmd == CMD_STREAM && jq_job.lookup);

	always_comb begin
		state_d  = state_q;
		unique_d = unique_q;
		idx_d    = idx_q;
		n_d      = n_q;
		jq_pop   = 1'b0;
		rq_push  = 1'b0;
		res      = '0;
		res.unique_total = unique_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q + 1'b1;
		v_we     = 1'b0;
		v_wa     = clr_q;
		v_wd     = 1'b0;
		k_we     = 1'b0;
		c_we     = 1'b0;
		c_wd     = '0;
		unique case (state_q)
			B_CLEAR: begin
				v_we = 1'b1;
				if (clr_q == IDX_LAST)
					state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!jq_empty && !rq_full) begin
					jq_pop = 1'b1;
					if (needs) begin
						rd_en   = 1'b1;
						rd_addr = jq_idx;
						idx_d   = jq_idx;
						n_d     = '0;
						state_d = B_PROBE;
					end else begin
						rq_push = 1'b1;
					end
				end
			end
			B_PROBE: begin
				unique case (job_q.cmd)
					CMD_READ: begin
						rq_push = 1'b1;
						res.entry_valid = v_rd;
						res.entry_kmer  = v_rd ? k_rd : '0;
						res.entry_count = v_rd ? c_rd : '0;
						state_d = B_IDLE;
					end
					CMD_INSERT: begin
						if (!v_rd) begin
							v_we = 1'b1;
							v_wa = idx_q;
							v_wd = 1'b1;
							k_we = 1'b1;
							c_we = 1'b1;
							if (unique_q != UNIQUE_MAX)
								unique_d = unique_q + 1'b1;
							rq_push = 1'b1;
							res.status = ST_ADDED;
							res.unique_total = unique_d;
							state_d = B_IDLE;
						end else if (hit) begin
							rq_push = 1'b1;
							res.status = ST_PRESENT;
							state_d = B_IDLE;
						end else if (last) begin
							rq_push = 1'b1;
							res.status = ST_FULL;
							state_d = B_IDLE;
						end else begin
							rd_en = 1'b1;
							idx_d = idx_q + 1'b1;
							n_d   = n_q + 1'b1;
						end
					end
					CMD_STREAM: begin
						res.window_full = 1'b1;
						if (hit) begin
							c_we = 1'b1;
							c_wd = (c_rd == COUNT_MAX) ? c_rd : c_rd + 1'b1;
							rq_push = 1'b1;
							res.matched = 1'b1;
							state_d = B_IDLE;
						end else if (!v_rd || last) begin
							rq_push = 1'b1;
							state_d = B_IDLE;
						end else begin
							rd_en = 1'b1;
							idx_d = idx_q + 1'b1;
							n_d   = n_q + 1'b1;
						end
					end
					default: begin
						rq_push = 1'b1;
						state_d = B_IDLE;
					end
				endcase
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			clr_q    <= '0;
			unique_q <= '0;
		end else begin
			state_q  <= state_d;
			unique_q <= unique_d;
			if (state_q == B_CLEAR)
				clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		n_q   <= n_d;
		if (jq_pop)
			job_q <= jq_job;
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vmem[v_wa] <= v_wd;
		if (k_we)
			kmem[idx_q] <= job_q.key;
		if (c_we)
			cmem[idx_q] <= c_wd;
		if (rd_en) begin
			v_rd <= vmem[rd_addr];
			k_rd <= kmem[rd_addr];
			c_rd <= cmem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/kmer_match_counter.sv
// ----------------------------------------------------------------------------
// kmer_match_counter
// Reference k-mer table with streamed-window match counting.
// ----------------------------------------------------------------------------
// After reset the block clears the slot valid bits and shows full meanwhile;
// configuration writes are taken throughout. The front end hands a stream,
// read or unused command straight to the job queue; the probe engine then
// starts the table read when it takes the job and probes one slot after
// another until a slot decides it, as the slot memory has a single read
// port. An insert first hashes the k-mer four bases at a time, during which
// no new item is taken. A two-entry queue sits between front end and probe
// engine and another holds finished results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmer_match_counter import kmc_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          cmd,
	input  wire logic                seq_start,
	input  wire logic [1:0]          nucleotide,
	input  wire logic [KMER_W-1:0]   kmer_in,
	input  wire logic [RIDX_W-1:0]   read_index,
	input  wire logic                cfg_we,
	input  wire logic [KLEN_W-1:0]   cfg_data,
	output logic                     empty,
	input  wire logic                pop,
	output logic [1:0]               status,
	output logic                     window_full,
	output logic                     matched,
	output logic                     entry_valid,
	output logic [KMER_W-1:0]        entry_kmer,
	output logic [COUNT_W-1:0]       entry_count,
	output logic [UNIQUE_W-1:0]      unique_total
);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int JW    = $bits(job_t) + IDX_W;

	logic          jq_push, jq_full, jq_pop, jq_empty, rq_push, rq_full, clearing;
	logic [JW-1:0] jq_din, jq_dout;
	result_t       res_in, res_out;

	kmc_front #(.IDX_W(IDX_W)) u_front (
		.clk, .arst_n, .push, .full, .cmd, .seq_start, .nucleotide, .kmer_in,
		.read_index, .cfg_we, .cfg_data, .clearing,
		.jq_push, .jq_data(jq_din), .jq_full
	);

	kmc_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_jobq (
		.clk, .arst_n, .push(jq_push), .din(jq_din), .full(jq_full),
		.pop(jq_pop), .dout(jq_dout), .empty(jq_empty)
	);

	kmc_back #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_back (
		.clk, .arst_n, .jq_empty, .jq_data(jq_dout), .jq_pop,
		.rq_full, .rq_push, .res(res_in), .clearing
	);

	kmc_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_resq (
		.clk, .arst_n, .push(rq_push), .din(res_in), .full(rq_full),
		.pop, .dout(res_out), .empty
	);

	assign status       = res_out.status;
	assign window_full  = res_out.window_full;
	assign matched      = res_out.matched;
	assign entry_valid  = res_out.entry_valid;
	assign entry_kmer   = res_out.entry_kmer;
	assign entry_count  = res_out.entry_count;
	assign unique_total = res_out.unique_total;

endmodule

`default_nettype wire

// File: rtl/kmc_checker.sv
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks of the k-mer match counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kmc_checker import kmc_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                push,
	input wire logic                full,
	input wire logic                empty,
	input wire logic                pop,
	input wire logic [1:0]          status,
	input wire logic                window_full,
	input wire logic                matched,
	input wire logic                entry_valid,
	input wire logic [KMER_W-1:0]   entry_kmer,
	input wire logic [COUNT_W-1:0]  entry_count,
	input wire logic [UNIQUE_W-1:0] unique_total
);
	logic [7:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 8'(push && !full) - 8'(pop && !empty);
	end

	`ASSERT_CLK(a_hold, !empty && !pop |=> !empty && $stable(status) && $stable(matched) && $stable(entry_kmer) && $stable(entry_count) && $stable(unique_total), "result changed while stalled")
	`ASSERT_CLK(a_origin, !empty |-> inflight_q != 8'd0, "result without a pending item")
	`ASSERT_CLK(a_unique, !empty && pop |=> empty || unique_total >= $past(unique_total), "unique total decreased")
	`ASSERT_CLK(a_match, !empty && matched |-> window_full && !entry_valid, "match outside a full window")

endmodule

bind kmer_match_counter kmc_checker u_kmc_checker (.*);

`default_nettype wire

// File: sim/tb_kmer_match_counter.sv
// ----------------------------------------------------------------------------
// tb_kmer_match_counter
// Self-checking bench: drives insert, stream, read and unused commands through
// the push/full queue, predicts every result from a behavioral copy of the
// k-mer table, rolling window and hash, and checks each popped result field by
// field. Sweeps k_length over extremes and finishes by filling the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_kmer_match_counter;
	import kmc_pkg::*;

	localparam int SLOTS      = 1024;
	localparam int STALL_MAX  = 20000;
	localparam int PHASE_ITEMS = 50;

	typedef struct {
		logic [1:0]  status;
		logic        window_full;
		logic        matched;
		logic        entry_valid;
		logic [63:0] entry_kmer;
		logic [31:0] entry_count;
		logic [10:0] unique_total;
	} kmc_rsp_t;

	typedef struct {
		cmd_t        c;
		bit          sq;
		logic [1:0]  nuc;
		logic [63:0] km;
		logic [9:0]  ri;
		bit          typed;
		status_t     st;
		bit          ev;
		int          un;
	} dir_row_t;

	logic        clk, arst_n, push, full, seq_start, cfg_we, empty, pop;
	logic [1:0]  cmd, nucleotide, status;
	logic [63:0] kmer_in, entry_kmer;
	logic [9:0]  read_index;
	logic [5:0]  cfg_data;
	logic        window_full, matched, entry_valid;
	logic [31:0] entry_count;
	logic [10:0] unique_total;

	bit          tbl_used [SLOTS];
	logic [63:0] tbl_key [SLOTS];
	logic [31:0] tbl_cnt [SLOTS];
	logic [63:0] win_bases, win_hash;
	int          win_fill, uniq_cnt;
	logic [5:0]  k_reg;

	kmc_rsp_t    pending_rsp [$];
	logic [63:0] known_kmers [$];
	int          err_cnt, idle_cycles, pop_stall;
	bit          no_idle, in_acc;

	kmer_match_counter DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.seq_start(seq_start), .nucleotide(nucleotide), .kmer_in(kmer_in),
		.read_index(read_index), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .status(status), .window_full(window_full),
		.matched(matched), .entry_valid(entry_valid), .entry_kmer(entry_kmer),
		.entry_count(entry_count), .unique_total(unique_total)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic logic [63:0] rot_left(logic [63:0] x, int r);
		r = r % 64;
		if (r == 0)
			return x;
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic int klen_eff();
		if (k_reg == 6'd0)
			return 1;
		if (k_reg > 6'd32)
			return 32;
		return int'(k_reg);
	endfunction

	function automatic logic [63:0] key_mask(int k);
		if (k >= 32)
			return '1;
		return (64'd1 << (2 * k)) - 64'd1;
	endfunction

	function automatic logic [63:0] kmer_hash(int k, logic [63:0] key);
		logic [63:0] h;
		h = '0;
		for (int i = 0; i < k; i++)
			h = rot_left(h, 2) ^ BASE_CONST[(key >> (2 * i)) & 64'd3];
		return h;
	endfunction

	function automatic int find_slot(logic [63:0] h, logic [63:0] key, output int free_slot);
		int idx;
		idx = int'(h & 64'(SLOTS - 1));
		free_slot = -1;
		for (int n = 0; n < SLOTS; n++) begin
			if (!tbl_used[idx]) begin
				free_slot = idx;
				return -1;
			end
			if (tbl_key[idx] == key)
				return idx;
			idx = (idx + 1) % SLOTS;
		end
		return -1;
	endfunction

	function automatic void clear_window();
		win_bases = '0;
		win_hash = '0;
		win_fill = 0;
	endfunction

	function automatic kmc_rsp_t predict_result(cmd_t c, bit sq, logic [1:0] nuc,
			logic [63:0] km, logic [9:0] ri);
		kmc_rsp_t r;
		int k, s, fs;
		logic [63:0] key;
		logic [1:0] outb;
		r = '{default: '0};
		k = klen_eff();
		case (c)
			CMD_INSERT: begin
				key = km & key_mask(k);
				s = find_slot(kmer_hash(k, key), key, fs);
				if (s >= 0) begin
					r.status = ST_PRESENT;
				end else if (fs >= 0) begin
					tbl_used[fs] = 1'b1;
					tbl_key[fs] = key;
					tbl_cnt[fs] = '0;
					if (uniq_cnt < 2047)
						uniq_cnt++;
					r.status = ST_ADDED;
				end else begin
					r.status = ST_FULL;
				end
			end
			CMD_STREAM: begin
				if (sq)
					clear_window();
				if (win_fill < k) begin
					win_bases |= 64'(nuc) << (2 * win_fill);
					win_hash = rot_left(win_hash, 2) ^ BASE_CONST[nuc];
					win_fill++;
				end else begin
					outb = win_bases[1:0];
					win_bases = (win_bases >> 2) | (64'(nuc) << (2 * (k - 1)));
					win_hash ^= rot_left(BASE_CONST[outb], 2 * (k - 1));
					win_hash = rot_left(win_hash, 2) ^ BASE_CONST[nuc];
				end
				if (win_fill >= k) begin
					r.window_full = 1'b1;
					s = find_slot(win_hash, win_bases, fs);
					if (s >= 0) begin
						r.matched = 1'b1;
						if (tbl_cnt[s] != '1)
							tbl_cnt[s]++;
					end
				end
			end
			CMD_READ: begin
				if (tbl_used[ri]) begin
					r.entry_valid = 1'b1;
					r.entry_kmer = tbl_key[ri];
					r.entry_count = tbl_cnt[ri];
				end
			end
			default: begin
			end
		endcase
		r.unique_total = 11'(uniq_cnt);
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(cmd_t c, bit sq, logic [1:0] nuc, logic [63:0] km,
			logic [9:0] ri, bit typed = 0, status_t st = ST_ADDED, bit ev = 0, int un = 0);
		kmc_rsp_t r;
		int g;
		@(negedge clk);
		push <= 1'b1;
		cmd <= c;
		seq_start <= sq;
		nucleotide <= nuc;
		kmer_in <= km;
		read_index <= ri;
		do
			@(posedge clk);
		while (full);
		r = predict_result(c, sq, nuc, km, ri);
		if (typed) begin
			r.status = st;
			r.entry_valid = ev;
			r.unique_total = 11'(un);
		end
		pending_rsp.push_back(r);
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_klen(logic [5:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		k_reg = v;
		clear_window();
		known_kmers.delete();
	endtask

	task automatic stream_sequence();
		logic [63:0] key;
		int k;
		k = klen_eff();
		if (known_kmers.size() != 0 && $urandom_range(0, 9) < 7) begin
			key = known_kmers[$urandom_range(0, known_kmers.size() - 1)];
		end else begin
			key = {$urandom, $urandom};
			send_item(CMD_INSERT, $urandom_range(0, 1), $urandom_range(0, 3), key,
				$urandom_range(0, 1023));
			key &= key_mask(k);
			known_kmers.push_back(key);
		end
		for (int i = 0; i < k; i++)
			send_item(CMD_STREAM, i == 0, 2'((key >> (2 * i)) & 64'd3), {$urandom, $urandom},
				$urandom_range(0, 1023));
		repeat ($urandom_range(0, 3))
			send_item(CMD_STREAM, 1'b0, $urandom_range(0, 3), {$urandom, $urandom},
				$urandom_range(0, 1023));
	endtask

	task automatic random_phase(int n_items);
		int r, sent, idx;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				stream_sequence();
				sent += klen_eff() + 1;
			end else begin
				if (r < 62) begin
					send_item(CMD_INSERT, $urandom_range(0, 1), $urandom_range(0, 3),
						{$urandom, $urandom}, $urandom_range(0, 1023));
				end else if (r < 77) begin
					idx = $urandom_range(0, 1023);
					for (int t = 0; t < 8 && !tbl_used[idx]; t++)
						idx = $urandom_range(0, 1023);
					send_item(CMD_READ, $urandom_range(0, 1), $urandom_range(0, 3),
						{$urandom, $urandom}, idx);
				end else if (r < 95) begin
					send_item(CMD_STREAM, $urandom_range(0, 9) == 0, $urandom_range(0, 3),
						{$urandom, $urandom}, $urandom_range(0, 1023));
				end else begin
					send_item(CMD_NOP, $urandom_range(0, 1), $urandom_range(0, 3),
						{$urandom, $urandom}, $urandom_range(0, 1023));
				end
				sent++;
			end
		end
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	always @(negedge clk) begin
		if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else begin
			pop <= 1'b1;
			if (!no_idle && $urandom_range(0, 99) < 30)
				pop_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		kmc_rsp_t e;
		in_acc = push && !full;
		if (arst_n && pop && !empty) begin
			in_acc = 1'b1;
			if (pending_rsp.size() == 0) begin
				$error("result popped with nothing expected");
				err_cnt++;
			end else begin
				e = pending_rsp.pop_front();
				check_field("status", e.status, status);
				check_field("window_full", e.window_full, window_full);
				check_field("matched", e.matched, matched);
				check_field("entry_valid", e.entry_valid, entry_valid);
				check_field("entry_kmer", e.entry_kmer, entry_kmer);
				check_field("entry_count", e.entry_count, entry_count);
				check_field("unique_total", e.unique_total, unique_total);
			end
		end
		if (in_acc)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	dir_row_t dir_rows [] = '{
		'{CMD_READ,   0, 0, 64'h0,                  10'd0,    1, ST_ADDED,   0, 0},
		'{CMD_READ,   0, 0, 64'h0,                  10'd1023, 1, ST_ADDED,   0, 0},
		'{CMD_NOP,    1, 3, 64'hffff_ffff_ffff_ffff, 10'd1023, 1, ST_ADDED,   0, 0},
		'{CMD_INSERT, 0, 0, 64'hffff_ffff_ffff_ffff, 10'd0,    1, ST_ADDED,   0, 1},
		'{CMD_INSERT, 0, 0, 64'h3fff_ffff_ffff_ffff, 10'd0,    1, ST_PRESENT, 0, 1},
		'{CMD_INSERT, 0, 0, 64'h0,                  10'd0,    1, ST_ADDED,   0, 2},
		'{CMD_INSERT, 0, 0, 64'hc000_0000_0000_0000, 10'd0,    1, ST_PRESENT, 0, 2},
		'{CMD_INSERT, 1, 2, 64'h0123_4567_89ab_cdef, 10'd0,    0, ST_ADDED,   0, 0},
		'{CMD_STREAM, 1, 3, 64'h0,                  10'd0,    0, ST_ADDED,   0, 0},
		'{CMD_STREAM, 0, 0, 64'h0,                  10'd0,    0, ST_ADDED,   0, 0},
		'{CMD_STREAM, 0, 1, 64'h0,                  10'd0,    0, ST_ADDED,   0, 0},
		'{CMD_STREAM, 0, 2, 64'h0,                  10'd0,    0, ST_ADDED,   0, 0},
		'{CMD_STREAM, 1, 0, 64'hffff_ffff_ffff_ffff, 10'd1023, 0, ST_ADDED,   0, 0},
		'{CMD_READ,   1, 3, 64'hffff_ffff_ffff_ffff, 10'h2aa,  0, ST_ADDED,   0, 0},
		'{CMD_READ,   0, 0, 64'h0,                  10'h155,  0, ST_ADDED,   0, 0},
		'{CMD_NOP,    0, 0, 64'h0,                  10'd0,    0, ST_ADDED,   0, 0}
	};

	logic [5:0] klen_plan [] = '{6'd0, 6'd1, 6'd63, 6'd2, 6'd3, 6'd21, 6'd42, 6'd4,
		6'd5, 6'd32};

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cmd = CMD_NOP;
		seq_start = 1'b0;
		nucleotide = '0;
		kmer_in = '0;
		read_index = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		pop = 1'b0;
		pop_stall = 0;
		no_idle = 1'b0;
		err_cnt = 0;
		idle_cycles = 0;
		uniq_cnt = 0;
		k_reg = 6'd31;
		clear_window();
		for (int i = 0; i < SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_cnt[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].c, dir_rows[i].sq, dir_rows[i].nuc, dir_rows[i].km,
				dir_rows[i].ri, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].ev,
				dir_rows[i].un);

		foreach (klen_plan[i]) begin
			set_klen(klen_plan[i]);
			no_idle = (i % 4 == 3);
			random_phase(PHASE_ITEMS);
		end

		no_idle = 1'b0;
		set_klen(6'd32);
		while (uniq_cnt < SLOTS)
			send_item(CMD_INSERT, 1'b0, 2'd0, {$urandom, $urandom}, 10'd0);
		repeat (3)
			send_item(CMD_INSERT, 1'b0, 2'd0, {$urandom, $urandom}, 10'd0);
		send_item(CMD_INSERT, 1'b0, 2'd0, 64'hffff_ffff_ffff_ffff, 10'd0);
		set_klen(6'd1);
		for (int i = 0; i < 4; i++)
			send_item(CMD_STREAM, i == 0, 2'(i), 64'h0, 10'd0);
		repeat (4)
			send_item(CMD_READ, 1'b0, 2'd0, 64'h0, $urandom_range(0, 1023));

		drain();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
